// File: rtl/crct_pkg.sv
// shared widths, codes and helpers for the circle and rectangle collision tester
package crct_pkg;

  localparam int unsigned S_TDATA_W  = 256;
  localparam int unsigned M_TDATA_W  = 72;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned NMAG_W     = 31;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned REM_W      = 36;
  localparam int unsigned NORM_FRAC  = 14;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned NUM_W      = 47;

  localparam logic signed [NORM_W-1:0] NORM_ONE  = 16'sd16384;
  localparam logic signed [NORM_W-1:0] NORM_DIAG = 16'sd11585;

  typedef enum logic {
    OP_CIRCLE = 1'b0,
    OP_RECT   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_NEG  = 2'b01,
    DIR_POS  = 2'b10
  } dir_e;

  // per-item control that rides along the pipeline
  typedef struct packed {
    op_e  op;
    dir_e dir_x;
    dir_e dir_y;
    logic neg_x;
    logic neg_y;
    logic zero;
    logic hit;
  } side_t;

  // one component of the unit face or corner normal
  function automatic logic signed [NORM_W-1:0] dir_norm(dir_e d, dir_e other);
    logic signed [NORM_W-1:0] m;
    m = (other == DIR_NONE) ? NORM_ONE : NORM_DIAG;
    unique case (d)
      DIR_POS: dir_norm = m;
      DIR_NEG: dir_norm = -m;
      default: dir_norm = '0;
    endcase
  endfunction

endpackage

// File: rtl/circle_rect_collision_test_core.sv
// narrow-phase 2d collision tester: circle-circle and rectangle-circle, pipelined
// throughput: one shape pair per cycle while the skid register is empty; the
// bit-serial square root (32 stages) and the two restoring dividers (15 stages)
// set the pipeline depth
// output register plus skid register; s_axis_tready is registered and drops only
// while the skid holds a result. rst_ni clears all valid bits asynchronously
module circle_rect_collision_test_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_x, a_y, a_radius, a_max_x, a_max_y, b_x, b_y, b_radius, zero pad
  input  logic [crct_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, normal_a_x, normal_a_y, normal_b_x, normal_b_y, zero pad
  output logic [crct_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import crct_pkg::*;

  // whole pipeline advances while the skid register is empty
  logic en;
  logic skid_v_q;
  assign en = !skid_v_q;
  assign s_axis_tready = en;

  // ---------------- input field unpack ----------------
  logic signed [COORD_W-1:0] in_a_x, in_a_y, in_a_max_x, in_a_max_y, in_b_x, in_b_y;
  logic [RAD_W-1:0] in_a_radius, in_b_radius;
  assign in_a_x      = s_axis_tdata[31:0];
  assign in_a_y      = s_axis_tdata[63:32];
  assign in_a_radius = s_axis_tdata[94:64];
  assign in_a_max_x  = s_axis_tdata[126:95];
  assign in_a_max_y  = s_axis_tdata[158:127];
  assign in_b_x      = s_axis_tdata[190:159];
  assign in_b_y      = s_axis_tdata[222:191];
  assign in_b_radius = s_axis_tdata[253:223];

  // ---------------- stage 1: clamp and operand select ----------------
  logic lt_x, lt_y, gt_x, gt_y;
  logic signed [COORD_W-1:0] cx, cy;
  logic s1_v_q;
  side_t side1;
  side_t s1_side_q;
  logic signed [COORD_W-1:0] s1_ux_q, s1_uy_q, s1_wx_q, s1_wy_q;
  logic [MAG_W-1:0] s1_lim_q;

  // min clamp first, then max clamp, so max wins on an inverted rectangle
  assign lt_x = in_b_x < in_a_x;
  assign lt_y = in_b_y < in_a_y;
  assign gt_x = lt_x ? (in_a_x > in_a_max_x) : (in_b_x > in_a_max_x);
  assign gt_y = lt_y ? (in_a_y > in_a_max_y) : (in_b_y > in_a_max_y);
  assign cx   = gt_x ? in_a_max_x : (lt_x ? in_a_x : in_b_x);
  assign cy   = gt_y ? in_a_max_y : (lt_y ? in_a_y : in_b_y);

  always_comb begin
    side1       = '0;
    side1.op    = op_e'(s_axis_tuser);
    side1.dir_x = gt_x ? DIR_POS : (lt_x ? DIR_NEG : DIR_NONE);
    side1.dir_y = gt_y ? DIR_POS : (lt_y ? DIR_NEG : DIR_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= side1;
      if (op_e'(s_axis_tuser) == OP_CIRCLE) begin
        // vector from circle a toward circle b
        s1_ux_q  <= in_b_x;
        s1_uy_q  <= in_b_y;
        s1_wx_q  <= in_a_x;
        s1_wy_q  <= in_a_y;
        s1_lim_q <= {1'b0, in_a_radius} + {1'b0, in_b_radius};
      end else begin
        // vector from circle centre to closest rectangle point
        s1_ux_q  <= cx;
        s1_uy_q  <= cy;
        s1_wx_q  <= in_b_x;
        s1_wy_q  <= in_b_y;
        s1_lim_q <= {1'b0, in_b_radius};
      end
    end
  end

  // ---------------- stage 2: 33-bit difference ----------------
  logic s2_v_q;
  side_t s2_side_q;
  logic signed [COORD_W:0] s2_dx_q, s2_dy_q;
  logic [MAG_W-1:0] s2_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_dx_q   <= {s1_ux_q[COORD_W-1], s1_ux_q} - {s1_wx_q[COORD_W-1], s1_wx_q};
      s2_dy_q   <= {s1_uy_q[COORD_W-1], s1_uy_q} - {s1_wy_q[COORD_W-1], s1_wy_q};
      s2_lim_q  <= s1_lim_q;
    end
  end

  // ---------------- stage 3: magnitudes ----------------
  logic s3_v_q;
  side_t side3;
  side_t s3_side_q;
  logic [MAG_W-1:0] s3_mx_q, s3_my_q, s3_lim_q;
  logic signed [COORD_W:0] abs_x, abs_y;

  assign abs_x = s2_dx_q[COORD_W] ? -s2_dx_q : s2_dx_q;
  assign abs_y = s2_dy_q[COORD_W] ? -s2_dy_q : s2_dy_q;

  always_comb begin
    side3       = s2_side_q;
    side3.neg_x = s2_dx_q[COORD_W];
    side3.neg_y = s2_dy_q[COORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= side3;
      s3_mx_q   <= abs_x[MAG_W-1:0];
      s3_my_q   <= abs_y[MAG_W-1:0];
      s3_lim_q  <= s2_lim_q;
    end
  end

  // ---------------- stage 4: squares, coarse normalize ----------------
  logic s4_v_q;
  side_t side4;
  side_t s4_side_q;
  logic [SQ_W-1:0] s4_sqx_q, s4_sqy_q, s4_limsq_q;
  logic [NMAG_W-1:0] s4_nx_q, s4_ny_q;
  logic [SQ_W-1:0] sqx4, sqy4, limsq4;
  logic [MAG_W-1:0] or4;
  logic [NMAG_W-1:0] a0, b0, a1, b1, a2, b2;

  assign sqx4   = s3_mx_q * s3_mx_q;
  assign sqy4   = s3_my_q * s3_my_q;
  assign limsq4 = s3_lim_q * s3_lim_q;
  assign or4    = s3_mx_q | s3_my_q;

  always_comb begin
    side4      = s3_side_q;
    side4.zero = (or4 == '0);
  end

  // move the larger magnitude toward bit 30: one right step or coarse left steps
  always_comb begin
    if (or4[MAG_W-1]) begin
      a0 = s3_mx_q[MAG_W-1:1];
      b0 = s3_my_q[MAG_W-1:1];
    end else begin
      a0 = s3_mx_q[NMAG_W-1:0];
      b0 = s3_my_q[NMAG_W-1:0];
    end
    if ((a0[30:15] | b0[30:15]) == '0) begin
      a1 = {a0[14:0], 16'b0};
      b1 = {b0[14:0], 16'b0};
    end else begin
      a1 = a0;
      b1 = b0;
    end
    if ((a1[30:23] | b1[30:23]) == '0) begin
      a2 = {a1[22:0], 8'b0};
      b2 = {b1[22:0], 8'b0};
    end else begin
      a2 = a1;
      b2 = b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q  <= side4;
      s4_sqx_q   <= sqx4;
      s4_sqy_q   <= sqy4;
      s4_limsq_q <= limsq4;
      s4_nx_q    <= a2;
      s4_ny_q    <= b2;
    end
  end

  // ---------------- stage 5: distance sum, fine normalize ----------------
  logic s5_v_q;
  side_t s5_side_q;
  logic [SQ_W:0] s5_sum_q;
  logic [SQ_W-1:0] s5_limsq_q;
  logic [NMAG_W-1:0] s5_nx_q, s5_ny_q;
  logic [NMAG_W-1:0] a3, b3, a4, b4, a5, b5;

  always_comb begin
    if ((s4_nx_q[30:27] | s4_ny_q[30:27]) == '0) begin
      a3 = {s4_nx_q[26:0], 4'b0};
      b3 = {s4_ny_q[26:0], 4'b0};
    end else begin
      a3 = s4_nx_q;
      b3 = s4_ny_q;
    end
    if ((a3[30:29] | b3[30:29]) == '0) begin
      a4 = {a3[28:0], 2'b0};
      b4 = {b3[28:0], 2'b0};
    end else begin
      a4 = a3;
      b4 = b3;
    end
    if ((a4[30] | b4[30]) == 1'b0) begin
      a5 = {a4[29:0], 1'b0};
      b5 = {b4[29:0], 1'b0};
    end else begin
      a5 = a4;
      b5 = b4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q  <= s4_side_q;
      s5_sum_q   <= {1'b0, s4_sqx_q} + {1'b0, s4_sqy_q};
      s5_limsq_q <= s4_limsq_q;
      s5_nx_q    <= a5;
      s5_ny_q    <= b5;
    end
  end

  // ---------------- stage 6: hit compare, normalized squares ----------------
  logic s6_v_q;
  side_t side6;
  side_t s6_side_q;
  logic [2*NMAG_W-1:0] s6_psx_q, s6_psy_q;
  logic [NMAG_W-1:0] s6_nx_q, s6_ny_q;
  logic [2*NMAG_W-1:0] psx6, psy6;

  assign psx6 = s5_nx_q * s5_nx_q;
  assign psy6 = s5_ny_q * s5_ny_q;

  always_comb begin
    side6     = s5_side_q;
    side6.hit = (s5_sum_q <= {1'b0, s5_limsq_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_side_q <= side6;
      s6_psx_q  <= psx6;
      s6_psy_q  <= psy6;
      s6_nx_q   <= s5_nx_q;
      s6_ny_q   <= s5_ny_q;
    end
  end

  // ---------------- stage 7 and square root stages ----------------
  typedef struct packed {
    side_t             side;
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [NMAG_W-1:0] nx;
    logic [NMAG_W-1:0] ny;
  } sq_t;

  logic [SQRT_STEPS:0] sq_v_q;
  sq_t sq_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].side <= s6_side_q;
      sq_q[0].rad  <= {2'b0, s6_psx_q} + {2'b0, s6_psy_q};
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].nx   <= s6_nx_q;
      sq_q[0].ny   <= s6_ny_q;
    end
  end

  // one result bit per stage, two radicand bits shifted in each time
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] rs, trial;
    assign rs    = {sq_q[k].rem[REM_W-3:0], sq_q[k].rad[SQ_W-1-2*k -: 2]};
    assign trial = {2'b0, sq_q[k].root, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1].side <= sq_q[k].side;
        sq_q[k+1].rad  <= sq_q[k].rad;
        sq_q[k+1].nx   <= sq_q[k].nx;
        sq_q[k+1].ny   <= sq_q[k].ny;
        if (rs >= trial) begin
          sq_q[k+1].rem  <= rs - trial;
          sq_q[k+1].root <= {sq_q[k].root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_q[k+1].rem  <= rs;
          sq_q[k+1].root <= {sq_q[k].root[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- division stages: round(m * 2^14 / len) ----------------
  typedef struct packed {
    side_t                side;
    logic [ROOT_W-1:0]    len;
    logic [NUM_W-1:0]     rx;
    logic [NUM_W-1:0]     ry;
    logic [DIV_STEPS-1:0] qx;
    logic [DIV_STEPS-1:0] qy;
  } dv_t;

  logic [DIV_STEPS:0] dv_v_q;
  dv_t dv_q [DIV_STEPS+1];
  logic [NUM_W-1:0] half_len;

  assign half_len = {{(NUM_W-ROOT_W+1){1'b0}}, sq_q[SQRT_STEPS].root[ROOT_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].side <= sq_q[SQRT_STEPS].side;
      dv_q[0].len  <= sq_q[SQRT_STEPS].root;
      dv_q[0].rx   <= {2'b0, sq_q[SQRT_STEPS].nx, {NORM_FRAC{1'b0}}} + half_len;
      dv_q[0].ry   <= {2'b0, sq_q[SQRT_STEPS].ny, {NORM_FRAC{1'b0}}} + half_len;
      dv_q[0].qx   <= '0;
      dv_q[0].qy   <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [NUM_W-1:0] dsh;
    assign dsh = {{(NUM_W-ROOT_W){1'b0}}, dv_q[j].len} << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j+1].side <= dv_q[j].side;
        dv_q[j+1].len  <= dv_q[j].len;
        if (dv_q[j].rx >= dsh) begin
          dv_q[j+1].rx <= dv_q[j].rx - dsh;
          dv_q[j+1].qx <= {dv_q[j].qx[DIV_STEPS-2:0], 1'b1};
        end else begin
          dv_q[j+1].rx <= dv_q[j].rx;
          dv_q[j+1].qx <= {dv_q[j].qx[DIV_STEPS-2:0], 1'b0};
        end
        if (dv_q[j].ry >= dsh) begin
          dv_q[j+1].ry <= dv_q[j].ry - dsh;
          dv_q[j+1].qy <= {dv_q[j].qy[DIV_STEPS-2:0], 1'b1};
        end else begin
          dv_q[j+1].ry <= dv_q[j].ry;
          dv_q[j+1].qy <= {dv_q[j].qy[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- result assembly ----------------
  side_t fin_side;
  logic signed [NORM_W-1:0] nrm_x, nrm_y, na_x, na_y, nb_x, nb_y;
  logic [M_TDATA_W-1:0] fin_data;

  assign fin_side = dv_q[DIV_STEPS].side;

  always_comb begin
    // a zero vector normalizes to zero
    if (fin_side.zero) begin
      nrm_x = '0;
      nrm_y = '0;
    end else begin
      nrm_x = {1'b0, dv_q[DIV_STEPS].qx};
      nrm_y = {1'b0, dv_q[DIV_STEPS].qy};
      if (fin_side.neg_x) nrm_x = -nrm_x;
      if (fin_side.neg_y) nrm_y = -nrm_y;
    end
    unique case (fin_side.op)
      OP_CIRCLE: begin
        na_x = nrm_x;
        na_y = nrm_y;
        nb_x = -nrm_x;
        nb_y = -nrm_y;
      end
      default: begin
        na_x = dir_norm(fin_side.dir_x, fin_side.dir_y);
        na_y = dir_norm(fin_side.dir_y, fin_side.dir_x);
        nb_x = nrm_x;
        nb_y = nrm_y;
      end
    endcase
  end

  assign fin_data = {7'b0, nb_y, nb_x, na_y, na_x, fin_side.hit};

  // ---------------- output register and skid ----------------
  logic out_v_q;
  logic [M_TDATA_W-1:0] out_data_q, skid_data_q;
  logic fin_v, pop;

  assign fin_v = dv_v_q[DIV_STEPS] && en;
  assign pop   = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (fin_v) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else                 out_v_q  <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (fin_v) begin
      if (out_v_q && !pop) skid_data_q <= fin_data;
      else                 out_data_q  <= fin_data;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/crct_checker.sv
// port-level assertions for the collision tester, bound to the top level
module crct_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [crct_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [crct_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import crct_pkg::*;

  logic signed [NORM_W-1:0] na_x, nb_x;
  assign na_x = m_axis_tdata[16:1];
  assign nb_x = m_axis_tdata[48:33];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled result
  a_fell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("tready dropped without output stall");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("tready low with no result waiting");

  // x components of the unit normals stay within one in q2.14
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (na_x <= NORM_ONE) && (na_x >= -NORM_ONE) &&
                      (nb_x <= NORM_ONE) && (nb_x >= -NORM_ONE))
    else $error("normal out of range");

endmodule

bind circle_rect_collision_test_core crct_checker u_crct_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the circle and rectangle collision tester
module testbench;
  import crct_pkg::*;

  typedef struct {
    op_e                op;
    logic signed [31:0] ax, ay;
    logic [30:0]        ar;
    logic signed [31:0] amx, amy, bx, by;
    logic [30:0]        br;
  } shape_pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] nax, nay, nbx, nby;
  } contact_t;

  typedef struct {
    shape_pair_t pair;
    logic        known;
    contact_t    want;
  } row_t;

  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 3000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // expected results in send order, indexed by running counts
  contact_t    expected_q[2048];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          idle_cycles = 0;
  int          recv_stall_pct = 0;
  logic        hold_on = 1'b0;
  row_t        rows[16];
  int          n_rows = 0;

  always #1 clk_i = ~clk_i;

  circle_rect_collision_test_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // q2.14 unit vector, zero stays zero
  function automatic void unit_vector(input longint x, input longint y,
                                      output logic signed [15:0] nx,
                                      output logic signed [15:0] ny);
    longint unsigned mx, my, m, n, root, bitv, qx, qy;
    mx = magnitude(x);
    my = magnitude(y);
    if (mx == 0 && my == 0) begin
      nx = '0;
      ny = '0;
      return;
    end
    m = (mx > my) ? mx : my;
    while (m >= 64'd1 << 31) begin
      mx >>= 1; my >>= 1; m >>= 1;
    end
    while (m < 64'd1 << 30) begin
      mx <<= 1; my <<= 1; m <<= 1;
    end
    n = mx * mx + my * my;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    qx = (mx * 16384 + root / 2) / root;
    qy = (my * 16384 + root / 2) / root;
    nx = (x < 0) ? -qx[15:0] : qx[15:0];
    ny = (y < 0) ? -qy[15:0] : qy[15:0];
  endfunction

  // exact dx^2 + dy^2 <= reach^2
  function automatic logic in_reach(longint dx, longint dy, longint unsigned reach);
    logic [127:0] ux, uy, ul;
    ux = magnitude(dx);
    uy = magnitude(dy);
    ul = reach;
    return (ux * ux + uy * uy) <= ul * ul;
  endfunction

  function automatic contact_t predict_contact(shape_pair_t p);
    contact_t c;
    longint   dx, dy, cx, cy, sgx, sgy;
    if (p.op == OP_CIRCLE) begin
      dx = longint'(p.bx) - longint'(p.ax);
      dy = longint'(p.by) - longint'(p.ay);
      unit_vector(dx, dy, c.nax, c.nay);
      c.nbx = -c.nax;
      c.nby = -c.nay;
      c.hit = in_reach(dx, dy, longint'(p.ar) + longint'(p.br));
    end else begin
      cx = p.bx; cy = p.by; sgx = 0; sgy = 0;
      // min clamp first, max clamp last so it wins on inverted rectangles
      if (cx < p.ax)  begin cx = p.ax;  sgx = -1; end
      if (cx > p.amx) begin cx = p.amx; sgx = 1;  end
      if (cy < p.ay)  begin cy = p.ay;  sgy = -1; end
      if (cy > p.amy) begin cy = p.amy; sgy = 1;  end
      unit_vector(sgx, sgy, c.nax, c.nay);
      unit_vector(cx - longint'(p.bx), cy - longint'(p.by), c.nbx, c.nby);
      c.hit = in_reach(cx - longint'(p.bx), cy - longint'(p.by), longint'(p.br));
    end
    return c;
  endfunction

  function automatic shape_pair_t make_pair(op_e op, int ax, int ay, int ar, int amx,
                                            int amy, int bx, int by, int br);
    shape_pair_t p;
    p.op = op; p.ax = ax; p.ay = ay; p.ar = ar[30:0]; p.amx = amx; p.amy = amy;
    p.bx = bx; p.by = by; p.br = br[30:0];
    return p;
  endfunction

  task automatic add_row(row_t r);
    rows[n_rows[3:0]] = r;
    n_rows++;
  endtask

  function automatic int rand_coord(int span_bits);
    int v;
    v = $urandom;
    return (span_bits >= 32) ? v : (v >>> (32 - span_bits));
  endfunction

  // mostly shapes near each other so hits and misses both happen; some raw noise
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int          sb, lo, hi, t;
    p.op = op_e'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 20) begin
      p.ax = $urandom; p.ay = $urandom; p.amx = $urandom; p.amy = $urandom;
      p.bx = $urandom; p.by = $urandom;
      p.ar = 31'($urandom); p.br = 31'($urandom);
    end else begin
      sb = $urandom_range(4, 26);
      p.ax = rand_coord(sb); p.ay = rand_coord(sb);
      p.amx = rand_coord(sb); p.amy = rand_coord(sb);
      // mostly well-formed rectangles
      if ($urandom_range(0, 9) != 0) begin
        if (p.amx < p.ax) begin t = p.ax; p.ax = p.amx; p.amx = t; end
        if (p.amy < p.ay) begin t = p.ay; p.ay = p.amy; p.amy = t; end
      end
      p.bx = rand_coord(sb + 1); p.by = rand_coord(sb + 1);
      lo = $urandom; hi = $urandom;
      p.ar = 31'((lo >>> (33 - sb)) & 32'h7fff_ffff);
      p.br = 31'((hi >>> (33 - sb)) & 32'h7fff_ffff);
      if ($urandom_range(0, 15) == 0) p.bx = p.ax;
      if ($urandom_range(0, 15) == 0) p.by = p.ay;
    end
    return p;
  endfunction

  task automatic send_pair(shape_pair_t p, contact_t want, int sender_idle_pct);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.op;
    // fields from the lowest bit up, two pad bits on top
    s_axis_tdata  <= {2'b00, p.br, p.by, p.bx, p.amy, p.amx, p.ar, p.ay, p.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q[exp_wr[10:0]] = want;
    exp_wr++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {S_TDATA_W{1'bx}} & '0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // receiver side: check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    contact_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.nax = m_axis_tdata[16:1];
      got.nay = m_axis_tdata[32:17];
      got.nbx = m_axis_tdata[48:33];
      got.nby = m_axis_tdata[64:49];
      results_seen++;
      hits_seen += got.hit;
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q[exp_rd[10:0]];
        exp_rd++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
        end
      end
    end
    m_axis_tready <= hold_on ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("timeout, nothing moving");
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // long receiver hold-off, counted here
  initial begin
    wait (recv_stall_pct == 1);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    row_t        r;
    contact_t    none;
    int          sender_pct;
    int          sent = 0;
    localparam int ONE = 65536;
    localparam int MINV = 32'h8000_0000;
    localparam int MAXV = 32'h7fff_ffff;
    none = '0;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;

    // directed rows; the known ones carry the obvious answer
    r.known = 1;
    r.pair = make_pair(OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0);                // coincident
    r.want = '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}; add_row(r);
    r.pair = make_pair(OP_CIRCLE, 0, 0, 5*ONE, 0, 0, 10*ONE, 0, 5*ONE);   // just touching
    r.want = '{1'b1, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0}; add_row(r);
    r.pair = make_pair(OP_CIRCLE, 0, 0, 4*ONE, 0, 0, 10*ONE, 0, 4*ONE);   // just apart
    r.want = '{1'b0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0}; add_row(r);
    r.pair = make_pair(OP_CIRCLE, 0, 0, 0, 0, 0, 0, -3*ONE, 0);
    r.want = '{1'b0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384}; add_row(r);
    r.pair = make_pair(OP_RECT, 0, 0, 0, 100*ONE, 100*ONE, 50*ONE, 50*ONE, ONE); // inside
    r.want = '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}; add_row(r);
    r.pair = make_pair(OP_RECT, 0, 0, 0, 10*ONE, 10*ONE, -5*ONE, 5*ONE, 5*ONE); // left face
    r.want = '{1'b1, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0}; add_row(r);
    r.pair = make_pair(OP_RECT, 0, 0, 0, 10*ONE, 10*ONE, 20*ONE, 20*ONE, ONE); // corner
    r.want = '{1'b0, 16'sd11585, 16'sd11585, -16'sd11585, -16'sd11585}; add_row(r);
    r.known = 0;
    r.want = none;
    r.pair = make_pair(OP_CIRCLE, MINV, MINV, MAXV, 0, 0, MAXV, MAXV, MAXV); add_row(r);
    r.pair = make_pair(OP_CIRCLE, MAXV, MINV, 0, -1, -1, MINV, MAXV, 0);     add_row(r);
    r.pair = make_pair(OP_CIRCLE, -1, 1, MAXV, 0, 0, MAXV, MINV, 1);         add_row(r);
    r.pair = make_pair(OP_RECT, 10*ONE, 10*ONE, 0, 0, 0, 5*ONE, 5*ONE, 7*ONE); // inverted
    add_row(r);
    r.pair = make_pair(OP_RECT, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV); add_row(r);
    r.pair = make_pair(OP_RECT, MAXV, MAXV, 0, MAXV, MAXV, MINV, MINV, MAXV);    add_row(r);
    r.pair = make_pair(OP_RECT, MINV, 0, 0, MINV, MAXV, MAXV, MINV, 0);          add_row(r);
    r.pair = make_pair(OP_RECT, 3, -7, 0, -2, 9, 1, 100, 91);                    add_row(r);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < n_rows; i++)
      send_pair(rows[i].pair, rows[i].known ? rows[i].want : predict_contact(rows[i].pair), 0);

    // phases: steady, sender gaps, receiver stalls, both, then back-pressure
    for (int phase = 0; phase < 5; phase++) begin
      sender_pct     = (phase == 1 || phase == 3) ? 57 : (phase == 3 ? 16 : 0);
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3 ? 16 : (phase == 4 ? 1 : 0));
      if (phase == 3) sender_pct = 16;
      for (int k = 0; k < 330; k++) begin
        shape_pair_t p;
        p = random_pair();
        send_pair(p, predict_contact(p), sender_pct);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 30;

    wait (exp_rd == exp_wr);
    repeat (80) @(posedge clk_i);

    $display("%0d directed and %0d random shape pairs, %0d results, %0d hits",
             n_rows, sent, results_seen, hits_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && exp_rd == exp_wr)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/crct_pkg.sv
rtl/circle_rect_collision_test_core.sv
rtl/crct_checker.sv
tb/testbench.sv
